// ----- design/jrlcg_pkg.sv -----
// Shared types and constants of the 48-bit LCG block.
package jrlcg_pkg;

  localparam int unsigned StateW = 48;
  localparam int unsigned ValueW = 32;
  localparam int unsigned BoundW = 31;
  localparam int unsigned DrawW  = 31;

  localparam logic [StateW-1:0] LcgMul = 48'h0005_DEEC_E66D;
  localparam logic [StateW-1:0] LcgAdd = 48'h0000_0000_000B;

  typedef enum logic [1:0] {
    CmdDraw32  = 2'd0,
    CmdBounded = 2'd1,
    CmdLoad    = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic latch_in;
    logic acc_init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic val_draw32;
    logic val_pow2;
    logic val_mod;
    logic val_zero;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic mul_last;
    logic div_last;
    logic pow2;
    logic reject;
  } dp_sts_t;

endpackage

// ----- design/java_random_lcg.sv -----
// Flow: a 32-bit draw or a power-of-two bounded draw goes through dispatch, the serial multiply
// of the 48-bit state in 16-bit slices, select and output load; a seed load or the unused command
// goes from dispatch to the output load; any other bound adds the one-bit-a-cycle remainder and a
// check, and each redraw repeats multiply, remainder and check. One request at a time, the next
// taken in the cycle after the result is loaded; the next is taken while a result waits in the output
// register. Reset (rst_ni low, asynchronous) clears the generator state to zero.
module java_random_lcg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [79:0] s_tdata_i,   // seed_value[47:0], bound[78:48], zero pad [79]
  input  logic [1:0]  s_tuser_i,   // cmd[1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [79:0] m_tdata_o    // value[31:0] (signed), seed_readback[79:32]
);

  jrlcg_pkg::dp_cmd_t           cmd;
  jrlcg_pkg::dp_sts_t           sts;
  logic [jrlcg_pkg::ValueW-1:0] out_value;
  logic [jrlcg_pkg::StateW-1:0] out_seed;

  jrlcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jrlcg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_cmd_i    (s_tuser_i),
    .in_seed_i   (s_tdata_i[47:0]),
    .in_bound_i  (s_tdata_i[78:48]),
    .out_value_o (out_value),
    .out_seed_o  (out_seed)
  );

  assign m_tdata_o = {out_seed, out_value};

endmodule

// ----- design/jrlcg_dp.sv -----
// Datapath: LCG state, serial constant multiply, restoring divider, result registers.
module jrlcg_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  jrlcg_pkg::dp_cmd_t                 cmd_i,
  output jrlcg_pkg::dp_sts_t                 sts_o,
  input  logic [1:0]                         in_cmd_i,
  input  logic [jrlcg_pkg::StateW-1:0]       in_seed_i,
  input  logic [jrlcg_pkg::BoundW-1:0]       in_bound_i,
  output logic [jrlcg_pkg::ValueW-1:0]       out_value_o,
  output logic [jrlcg_pkg::StateW-1:0]       out_seed_o
);

  logic [1:0]                         cmd_q;
  logic [jrlcg_pkg::BoundW-1:0]       bound_q;
  logic [jrlcg_pkg::StateW-1:0]       state_q, state_d;
  logic [jrlcg_pkg::StateW-1:0]       acc_q, acc_d;
  logic [1:0]                         mul_idx_q;
  logic [4:0]                         div_idx_q;
  logic [jrlcg_pkg::BoundW-1:0]       rem_q, rem_d;
  logic [jrlcg_pkg::ValueW-1:0]       value_q, value_d;
  logic [jrlcg_pkg::ValueW-1:0]       out_value_q;
  logic [jrlcg_pkg::StateW-1:0]       out_seed_q;

  logic [15:0]                        chunk;
  logic [50:0]                        pp;
  logic [jrlcg_pkg::StateW-1:0]       pp_sh;
  logic [jrlcg_pkg::DrawW-1:0]        r;
  logic [jrlcg_pkg::BoundW:0]         rem_sh;
  logic [61:0]                        prod;
  logic [jrlcg_pkg::ValueW-1:0]       chk_sum;

  assign r = state_q[jrlcg_pkg::StateW-1 -: jrlcg_pkg::DrawW];

  // one 16-bit slice of the state times the multiplier per cycle
  always_comb begin
    case (mul_idx_q)
      2'd0:    chunk = state_q[15:0];
      2'd1:    chunk = state_q[31:16];
      2'd2:    chunk = state_q[47:32];
      default: chunk = '0;
    endcase
    pp = 51'(chunk) * 51'(jrlcg_pkg::LcgMul);
    case (mul_idx_q)
      2'd0:    pp_sh = pp[47:0];
      2'd1:    pp_sh = {pp[31:0], 16'b0};
      2'd2:    pp_sh = {pp[15:0], 32'b0};
      default: pp_sh = '0;
    endcase
    acc_d = acc_q + pp_sh;
  end

  always_comb begin
    state_d = state_q;
    if (cmd_i.latch_in && in_cmd_i == jrlcg_pkg::CmdLoad) begin
      state_d = in_seed_i ^ jrlcg_pkg::LcgMul;
    end else if (cmd_i.mul_step && sts_o.mul_last) begin
      state_d = acc_d;
    end
  end

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q, r[div_idx_q]};
    if (rem_sh >= {1'b0, bound_q}) begin
      rem_d = jrlcg_pkg::BoundW'(rem_sh - {1'b0, bound_q});
    end else begin
      rem_d = rem_sh[jrlcg_pkg::BoundW-1:0];
    end
  end

  assign prod    = 62'(bound_q) * 62'(r);
  assign chk_sum = {1'b0, r} - {1'b0, rem_q} + {1'b0, bound_q} - 32'd1;

  always_comb begin
    value_d = value_q;
    if (cmd_i.val_draw32) begin
      value_d = state_q[jrlcg_pkg::StateW-1 -: jrlcg_pkg::ValueW];
    end else if (cmd_i.val_pow2) begin
      value_d = {1'b0, prod[61:31]};
    end else if (cmd_i.val_mod) begin
      value_d = {1'b0, rem_q};
    end else if (cmd_i.val_zero) begin
      value_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      mul_idx_q <= '0;
      div_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_i.acc_init) begin
        mul_idx_q <= '0;
      end else if (cmd_i.mul_step) begin
        mul_idx_q <= mul_idx_q + 2'd1;
      end
      if (cmd_i.div_init) begin
        div_idx_q <= 5'(jrlcg_pkg::DrawW - 1);
      end else if (cmd_i.div_step) begin
        div_idx_q <= div_idx_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cmd_q   <= in_cmd_i;
      bound_q <= in_bound_i;
    end
    if (cmd_i.acc_init) begin
      acc_q <= jrlcg_pkg::LcgAdd;
    end else if (cmd_i.mul_step) begin
      acc_q <= acc_d;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
    end
    value_q <= value_d;
    if (cmd_i.out_load) begin
      out_value_q <= value_q;
      out_seed_q  <= state_q ^ jrlcg_pkg::LcgMul;
    end
  end

  assign sts_o.cmd      = jrlcg_pkg::cmd_e'(cmd_q);
  assign sts_o.mul_last = (mul_idx_q == 2'd2);
  assign sts_o.div_last = (div_idx_q == 5'd0);
  assign sts_o.pow2     = ((bound_q & (~bound_q + 31'd1)) == bound_q);
  assign sts_o.reject   = chk_sum[jrlcg_pkg::ValueW-1];

  assign out_value_o = out_value_q;
  assign out_seed_o  = out_seed_q;

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.mul_step && sts_o.mul_last) && !cmd_i.latch_in |=> $stable(state_q))
    else $error("LCG state changed outside a step or load");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < bound_q))
    else $error("partial remainder not below bound");

  a_pow2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.val_pow2 |=> (value_q < {1'b0, bound_q}) || (bound_q == '0))
    else $error("power-of-two draw out of range");

endmodule

// ----- design/jrlcg_ctrl.sv -----
// Controller: sequences multiply, divide and redraw steps and the output register.
module jrlcg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  input  jrlcg_pkg::dp_sts_t    sts_i,
  output jrlcg_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    SIdle = 7'b0000001,
    SDisp = 7'b0000010,
    SMul  = 7'b0000100,
    SSel  = 7'b0001000,
    SDiv  = 7'b0010000,
    SChk  = 7'b0100000,
    SDone = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   m_tvalid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = SDisp;
        end
      end
      SDisp: begin
        case (sts_i.cmd) inside
          jrlcg_pkg::CmdDraw32, jrlcg_pkg::CmdBounded: begin
            cmd_o.acc_init = 1'b1;
            state_d        = SMul;
          end
          default: begin
            cmd_o.val_zero = 1'b1;
            state_d        = SDone;
          end
        endcase
      end
      SMul: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          state_d = SSel;
        end
      end
      SSel: begin
        if (sts_i.cmd == jrlcg_pkg::CmdDraw32) begin
          cmd_o.val_draw32 = 1'b1;
          state_d          = SDone;
        end else if (sts_i.pow2) begin
          cmd_o.val_pow2 = 1'b1;
          state_d        = SDone;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = SDiv;
        end
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = SChk;
        end
      end
      SChk: begin
        // rejected draw: step the generator again
        if (sts_i.reject) begin
          cmd_o.acc_init = 1'b1;
          state_d        = SMul;
        end else begin
          cmd_o.val_mod = 1'b1;
          state_d       = SDone;
        end
      end
      SDone: begin
        if (!m_tvalid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_tvalid_q;

  a_idle_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !(cmd_o.mul_step || cmd_o.div_step))
    else $error("request taken while arithmetic busy");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> m_tvalid_o && state_q == SIdle)
    else $error("result load did not raise valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |-> !cmd_o.out_load)
    else $error("pending result overwritten");

endmodule

// ----- test/java_random_lcg_test.sv -----
// Testbench of java_random_lcg: directed and random requests checked against a predictor.
module java_random_lcg_test;
  timeunit 1ns;
  timeprecision 1ps;

  // m_tdata_o layout, lowest field last
  typedef struct packed {
    logic [jrlcg_pkg::StateW-1:0]        seed_readback;
    logic signed [jrlcg_pkg::ValueW-1:0] value;
  } draw_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [79:0] s_tdata_i;   // seed_value[47:0], bound[78:48], zero pad [79]
  logic [1:0]  s_tuser_i;   // cmd[1:0]
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [79:0] m_tdata_o;   // value[31:0], seed_readback[79:32]

  logic [jrlcg_pkg::StateW-1:0] gen_state;
  draw_result_t                 expected_draws_q[$];
  int unsigned                  fail_count;
  int unsigned                  send_idle_pct;
  int unsigned                  recv_idle_pct;
  int unsigned                  rx_hold_cycles;

  java_random_lcg dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Step the generator and return the top nbits of the new state.
  function automatic logic [31:0] lcg_next_bits(input int unsigned nbits);
    gen_state = gen_state * jrlcg_pkg::LcgMul + jrlcg_pkg::LcgAdd;
    return 32'(gen_state >> (jrlcg_pkg::StateW - nbits));
  endfunction

  function automatic logic [31:0] lcg_below(input logic [jrlcg_pkg::BoundW-1:0] bound);
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] v;
    logic [63:0] prod;
    b = {1'b0, bound};
    // zero and powers of two take the multiply path
    if ((b & (-b)) == b) begin
      r = lcg_next_bits(jrlcg_pkg::DrawW);
      prod = 64'(b) * 64'(r);
      return 32'(prod >> jrlcg_pkg::DrawW);
    end
    do begin
      r = lcg_next_bits(jrlcg_pkg::DrawW);
      v = r % b;
    end while (((r - v + (b - 32'd1)) & 32'h8000_0000) != 32'd0);
    return v;
  endfunction

  function automatic draw_result_t lcg_predict(input jrlcg_pkg::cmd_e cmd,
                                               input logic [jrlcg_pkg::StateW-1:0] seed,
                                               input logic [jrlcg_pkg::BoundW-1:0] bound);
    draw_result_t res;
    res.value = '0;
    case (cmd)
      jrlcg_pkg::CmdDraw32:  res.value = lcg_next_bits(jrlcg_pkg::ValueW);
      jrlcg_pkg::CmdBounded: res.value = lcg_below(bound);
      jrlcg_pkg::CmdLoad:    gen_state = seed ^ jrlcg_pkg::LcgMul;
      default: ;
    endcase
    res.seed_readback = gen_state ^ jrlcg_pkg::LcgMul;
    return res;
  endfunction

  // Called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_req(input jrlcg_pkg::cmd_e cmd,
                          input logic [jrlcg_pkg::StateW-1:0] seed,
                          input logic [jrlcg_pkg::BoundW-1:0] bound);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {1'b0, bound, seed};
    s_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    expected_draws_q.insert(expected_draws_q.size(), lcg_predict(cmd, seed, bound));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (expected_draws_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [jrlcg_pkg::BoundW-1:0] pick_bound();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return 31'(1) << $urandom_range(30);
      3, 4:    return 31'($urandom_range(100, 1));
      5, 6:    return 31'($urandom_range(32'h7FFF_FFFF, 32'h4000_0001));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [jrlcg_pkg::StateW-1:0] pick_seed();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic jrlcg_pkg::cmd_e pick_cmd();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return jrlcg_pkg::CmdDraw32;
    if (roll < 75) return jrlcg_pkg::CmdBounded;
    if (roll < 90) return jrlcg_pkg::CmdLoad;
    return jrlcg_pkg::CmdNone;
  endfunction

  // Readback straight after reset, the unused command, and plain draws.
  task automatic test_reset_state();
    send_req(jrlcg_pkg::CmdNone, '1, '1);
    send_req(jrlcg_pkg::CmdDraw32, '0, '0);
    send_req(jrlcg_pkg::CmdDraw32, '1, '1);
    send_req(jrlcg_pkg::CmdNone, '0, '0);
  endtask

  task automatic test_bounded_edges();
    send_req(jrlcg_pkg::CmdBounded, '0, 31'd0);
    send_req(jrlcg_pkg::CmdBounded, '0, 31'd1);
    send_req(jrlcg_pkg::CmdBounded, '0, 31'd2);
    send_req(jrlcg_pkg::CmdBounded, '0, 31'd3);
    send_req(jrlcg_pkg::CmdBounded, '0, 31'h4000_0000);
    send_req(jrlcg_pkg::CmdBounded, '0, 31'h4000_0001);   // redraws often
    send_req(jrlcg_pkg::CmdBounded, '0, 31'h4000_0001);
    send_req(jrlcg_pkg::CmdBounded, '1, 31'h7FFF_FFFF);
    send_req(jrlcg_pkg::CmdBounded, '0, 31'h5555_5555);
  endtask

  task automatic test_seed_loads();
    send_req(jrlcg_pkg::CmdLoad, '0, '1);
    send_req(jrlcg_pkg::CmdDraw32, '0, '0);
    send_req(jrlcg_pkg::CmdLoad, '1, '0);
    send_req(jrlcg_pkg::CmdBounded, '0, 31'd10);
    send_req(jrlcg_pkg::CmdLoad, jrlcg_pkg::LcgMul, '0);   // state becomes zero
    send_req(jrlcg_pkg::CmdDraw32, '0, '0);
    send_req(jrlcg_pkg::CmdLoad, 48'hA5A5_5A5A_F00F, '0);
    send_req(jrlcg_pkg::CmdBounded, '0, 31'd1000);
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned tx_pct, input int unsigned rx_pct);
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    repeat (n_items) send_req(pick_cmd(), pick_seed(), pick_bound());
    drain_results();
  endtask

  // Receiver holds off while requests keep coming, so the block backs up.
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    rx_hold_cycles = 400;
    @(negedge clk_i);
    repeat (40) send_req(pick_cmd(), pick_seed(), pick_bound());
    drain_results();
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_tvalid_i     = 1'b0;
    s_tdata_i      = '0;
    s_tuser_i      = jrlcg_pkg::CmdDraw32;
    gen_state      = '0;
    fail_count     = 0;
    send_idle_pct  = 30;
    recv_idle_pct  = 53;
    rx_hold_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_bounded_edges();
    test_seed_loads();
    test_random_traffic(320, 30, 53);
    test_random_traffic(320, 53, 30);
    test_output_hold_off();
    test_random_traffic(320, 0, 0);

    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles != 0) begin
        m_tready_i <= 1'b0;
        rx_hold_cycles = rx_hold_cycles - 1;
      end else begin
        m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    draw_result_t got;
    draw_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = m_tdata_o;
      if (expected_draws_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata_o);
        fail_count = fail_count + 1;
      end else begin
        want = expected_draws_q.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, got.value);
          fail_count = fail_count + 1;
        end
        if (got.seed_readback !== want.seed_readback) begin
          $display("%0t: seed_readback expected %h actual %h", $time,
                   want.seed_readback, got.seed_readback);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
